// ----- rtl/weighted_histogram_accumulator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the weighted histogram accumulator
// Concurrent checks that compile away when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_HISTOGRAM_ACCUMULATOR_CORE_DEFINES_SVH
`define WEIGHTED_HISTOGRAM_ACCUMULATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define WHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define WHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define WHA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/whac_pkg.sv -----
// ----------------------------------------------------------------------------
// whac_pkg
// Types, constants and saturating helpers for the histogram accumulator
// ----------------------------------------------------------------------------
`default_nettype none
package whac_pkg;
  localparam int MAX_BINS = 254;
  localparam int BIN_CAP  = (MAX_BINS < 254) ? MAX_BINS : 254;
  localparam logic [7:0] BIN_CAP_V = 8'(BIN_CAP);

  localparam logic [1:0] OP_WEIGHTED   = 2'd0;
  localparam logic [1:0] OP_UNWEIGHTED = 2'd1;
  localparam logic [1:0] OP_READ       = 2'd2;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  localparam logic [2:0] REG_LOWER = 3'd0;
  localparam logic [2:0] REG_UPPER = 3'd1;
  localparam logic [2:0] REG_SCALE = 3'd2;
  localparam logic [2:0] REG_BINS  = 3'd3;
  localparam logic [2:0] REG_FOLD  = 3'd4;

  localparam logic [47:0] ONE_Q16 = 48'd65536;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [47:0] count;
    logic [63:0] variance;
  } whac_wr_t;

  function automatic logic [47:0] cnt_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      cnt_add = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      cnt_add = s[47:0];
    end
  endfunction

  function automatic logic [63:0] var_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    var_add = s[64] ? {64{1'b1}} : s[63:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/whac_store.sv -----
// ----------------------------------------------------------------------------
// whac_store
// Count and variance memories with per-entry valid bits and a registered read
// ----------------------------------------------------------------------------
`default_nettype none
module whac_store (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire whac_pkg::whac_wr_t wr,
  input  wire logic              rd_en,
  input  wire logic [7:0]        rd_addr,
  output logic [47:0]            rd_count,
  output logic [63:0]            rd_variance
);
  import whac_pkg::*;

  logic [47:0] count_mem [256];
  logic [63:0] var_mem [256];
  logic [255:0] valid;
  logic [47:0] count_q;
  logic [63:0] var_q;
  logic        valid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      count_mem[wr.addr] <= wr.count;
      var_mem[wr.addr]   <= wr.variance;
    end
    if (rd_en) begin
      count_q <= count_mem[rd_addr];
      var_q   <= var_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr.en) valid[wr.addr] <= 1'b1;
      if (rd_en) valid_q <= valid[rd_addr];
    end
  end

  // entries never written read as zero
  assign rd_count    = valid_q ? count_q : '0;
  assign rd_variance = valid_q ? var_q : '0;
endmodule
`default_nettype wire

// ----- rtl/whac_isqrt.sv -----
// ----------------------------------------------------------------------------
// whac_isqrt
// Digit-by-digit integer square root of a 64-bit value, two bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module whac_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] value,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] radicand;
  logic [33:0] rem;
  logic [4:0]  step;
  logic        busy;
  logic [33:0] rem_shift;
  logic [33:0] trial;

  assign rem_shift = {rem[31:0], radicand[63:62]};
  assign trial     = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      radicand <= value;
      rem      <= '0;
      root     <= '0;
    end else if (busy) begin
      radicand <= {radicand[61:0], 2'b00};
      if (rem_shift >= trial) begin
        rem  <= rem_shift - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/weighted_histogram_accumulator_core.sv -----
// Sample beat: accepted, then multiply, store read and write back before the next beat.
// Read beat: three store reads for flow folding, then the square root unit;
//   the result is registered once the root is done and the output can take it.
// One beat is in flight at a time; a finished result waits in the output register.
// Reset (synchronous) restores the register defaults and clears the store valid bits,
//   so there is no clearing pass.
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator_core
// Weighted histogram with read-modify-write store, flow folding and error readout
// ----------------------------------------------------------------------------
`default_nettype none
`include "weighted_histogram_accumulator_core_defines.svh"
module weighted_histogram_accumulator_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [71:0]  s_tdata,   // sample_value, sample_weight, bin_index
  input  wire logic [1:0]   s_tuser,   // opcode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata    // bin_count, bin_variance, bin_error
);
  import whac_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_MUL  = 10'b0000000010,
    ST_ADDR = 10'b0000000100,
    ST_UPD  = 10'b0000001000,
    ST_RDI  = 10'b0000010000,
    ST_RDA  = 10'b0000100000,
    ST_RDB  = 10'b0001000000,
    ST_RDC  = 10'b0010000000,
    ST_SQRT = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [31:0] lower_edge, upper_edge, bin_scale;
  logic [7:0]  bins_in_use;
  logic        fold_flow;
  logic        cfg_wr;

  logic [1:0]  op;
  logic [31:0] value, weight;
  logic [7:0]  index;
  logic        under, over;
  logic [63:0] prod, wsq;
  logic [7:0]  bin;
  logic [7:0]  n_eff;
  logic [7:0]  n_plus;
  logic [31:0] diff, abs_w;

  logic        rd_en;
  logic [7:0]  rd_addr;
  logic [47:0] rd_count;
  logic [63:0] rd_variance;
  whac_wr_t    wr;

  logic [47:0] acc_c, acc_c_next;
  logic [63:0] acc_v, acc_v_next;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic        accept, load_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_edge  <= 32'd0;
      upper_edge  <= 32'd65536;
      bin_scale   <= 32'd16646144;
      bins_in_use <= 8'd254;
      fold_flow   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_LOWER: lower_edge  <= pwdata;
        REG_UPPER: upper_edge  <= pwdata;
        REG_SCALE: bin_scale   <= pwdata;
        REG_BINS:  bins_in_use <= pwdata[7:0];
        REG_FOLD:  fold_flow   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LOWER: prdata = lower_edge;
      REG_UPPER: prdata = upper_edge;
      REG_SCALE: prdata = bin_scale;
      REG_BINS:  prdata = {24'd0, bins_in_use};
      REG_FOLD:  prdata = {31'd0, fold_flow};
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    n_eff = bins_in_use;
    if (n_eff < 8'd1) n_eff = 8'd1;
    if (n_eff > BIN_CAP_V) n_eff = BIN_CAP_V;
  end
  assign n_plus = n_eff + 8'd1;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= s_tuser;
      value  <= s_tdata[31:0];
      weight <= s_tdata[63:32];
      index  <= s_tdata[71:64];
    end
  end

  assign diff  = value - lower_edge;
  assign abs_w = weight[31] ? (32'd0 - weight) : weight;

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      under <= $signed(value) < $signed(lower_edge);
      over  <= $signed(value) >= $signed(upper_edge);
      prod  <= diff * bin_scale;
      wsq   <= abs_w * abs_w;
    end
  end

  always_comb begin
    if (under) bin = 8'd0;
    else if (over) bin = n_plus;
    else if (prod[63:32] >= {24'd0, n_eff}) bin = n_eff;
    else bin = prod[39:32] + 8'd1;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      ST_ADDR: begin rd_en = 1'b1; rd_addr = bin; end
      ST_RDI:  begin rd_en = 1'b1; rd_addr = index; end
      ST_RDA:  begin rd_en = 1'b1; rd_addr = 8'd0; end
      ST_RDB:  begin rd_en = 1'b1; rd_addr = n_plus; end
      default: ;
    endcase
  end

  logic [7:0] bin_q;
  always_ff @(posedge clk) begin
    if (state == ST_ADDR) bin_q <= bin;
  end

  always_comb begin
    wr.en       = (state == ST_UPD);
    wr.addr     = bin_q;
    wr.count    = cnt_add(rd_count, (op == OP_WEIGHTED) ?
                  {{16{weight[31]}}, weight} : ONE_Q16);
    wr.variance = (op == OP_WEIGHTED) ? var_add(rd_variance, wsq) : rd_variance;
  end

  whac_store u_store (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_count    (rd_count),
    .rd_variance (rd_variance)
  );

  // folding: underflow into bin 1, overflow into bin n, flow bins read zero
  always_comb begin
    acc_c_next = acc_c;
    acc_v_next = acc_v;
    unique case (state)
      ST_RDA: begin
        acc_c_next = rd_count;
        acc_v_next = rd_variance;
      end
      ST_RDB: begin
        if (fold_flow && index == 8'd1) begin
          acc_c_next = cnt_add(acc_c, rd_count);
          acc_v_next = var_add(acc_v, rd_variance);
        end
      end
      ST_RDC: begin
        if (fold_flow && index == n_eff) begin
          acc_c_next = cnt_add(acc_c, rd_count);
          acc_v_next = var_add(acc_v, rd_variance);
        end
        if (fold_flow && (index == 8'd0 || index == n_plus)) begin
          acc_c_next = '0;
          acc_v_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_c <= acc_c_next;
    acc_v <= acc_v_next;
  end

  assign sq_start = (state == ST_RDC);

  whac_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (acc_v_next),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_READ) state_next = ST_RDI;
          else if (s_tuser == OP_WEIGHTED || s_tuser == OP_UNWEIGHTED) state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_ADDR;
      ST_ADDR: state_next = ST_UPD;
      ST_UPD:  state_next = ST_IDLE;
      ST_RDI:  state_next = ST_RDA;
      ST_RDA:  state_next = ST_RDB;
      ST_RDB:  state_next = ST_RDC;
      ST_RDC:  state_next = ST_SQRT;
      ST_SQRT: if (sq_done) state_next = ST_DONE;
      ST_DONE: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) m_tdata <= {sq_root, acc_v, acc_c};
  end

  `WHA_ASSERT_IMPL(a_wr_only_samples, clk, rst, wr.en, op != OP_READ)
  `WHA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept && s_tuser != OP_UNUSED, state != ST_IDLE)
  `WHA_ASSERT_IMPL(a_done_in_sqrt, clk, rst, sq_done, state == ST_SQRT)
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the weighted histogram accumulator: sample and read beats stream in,
// a histogram model predicts all but typed readouts, registers change between phases
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import whac_pkg::*;

  localparam longint CNT_HI = 64'sh7FFFFFFFFFFF;
  localparam longint CNT_LO = -64'sh800000000000;
  localparam int     LIMIT  = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;   // sample_value, sample_weight, bin_index
  logic [1:0] s_tuser = '0;    // opcode
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [143:0] m_tdata;       // bin_count, bin_variance, bin_error

  weighted_histogram_accumulator_core uut (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic [47:0] count;
    logic [63:0] variance;
    logic [31:0] err;
  } readout_t;

  // model state
  logic [31:0] h_lower, h_upper, h_scale;
  logic [7:0]  h_bins;
  logic        h_fold;
  longint      h_count[256];
  logic [63:0] h_var[256];

  readout_t readouts_due[$];
  int       errors = 0;
  int       reads_seen = 0, samples_sent = 0;
  int       cycles = 0;
  bit       hold_long = 1'b0;

  function automatic longint sat_count(longint a, longint b);
    longint s;
    s = a + b;
    if (s > CNT_HI) s = CNT_HI;
    if (s < CNT_LO) s = CNT_LO;
    return s;
  endfunction

  function automatic logic [63:0] sat_var(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] root_of(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic int used_bins();
    if (h_bins < 1) return 1;
    if (h_bins > BIN_CAP) return BIN_CAP;
    return h_bins;
  endfunction

  function automatic int bin_of(logic signed [31:0] x, int n);
    longint d;
    logic [63:0] p;
    logic [63:0] b;
    if (x < $signed(h_lower)) return 0;
    if (x >= $signed(h_upper)) return n + 1;
    d = longint'(x) - longint'($signed(h_lower));
    p = 64'(d) * {32'd0, h_scale};
    b = (p >> 32) + 1;
    if (b > n) b = n;
    return int'(b);
  endfunction

  // updates the histogram, pushes the readout if the beat is a read
  task automatic histogram_apply(logic [1:0] op, logic [31:0] val, logic [31:0] w,
                                 logic [7:0] idx);
    int n, b;
    longint ws;
    logic [63:0] aw;
    readout_t r;
    longint c;
    logic [63:0] v;
    n = used_bins();
    if (op == OP_WEIGHTED || op == OP_UNWEIGHTED) begin
      b = bin_of(val, n);
      if (op == OP_WEIGHTED) begin
        ws = longint'($signed(w));
        aw = ws < 0 ? 64'(-ws) : 64'(ws);
        h_count[b] = sat_count(h_count[b], ws);
        h_var[b] = sat_var(h_var[b], aw * aw);
      end else begin
        h_count[b] = sat_count(h_count[b], 65536);
      end
    end else if (op == OP_READ) begin
      c = h_count[idx];
      v = h_var[idx];
      if (h_fold) begin
        if (idx == 0 || idx == n + 1) begin
          c = 0;
          v = 0;
        end else begin
          if (idx == 1) begin
            c = sat_count(c, h_count[0]);
            v = sat_var(v, h_var[0]);
          end
          if (idx == n) begin
            c = sat_count(c, h_count[n + 1]);
            v = sat_var(v, h_var[n + 1]);
          end
        end
      end
      r.count = c[47:0];
      r.variance = v;
      r.err = root_of(v);
      readouts_due.push_back(r);
    end
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LOWER: h_lower = val;
      REG_UPPER: h_upper = val;
      REG_SCALE: h_scale = val;
      REG_BINS:  h_bins = val[7:0];
      default:   h_fold = val[0];
    endcase
  endtask

  // offers one beat, random gaps come from the burst logic in the caller
  task automatic send_beat(logic [1:0] op, logic [31:0] val, logic [31:0] w,
                           logic [7:0] idx);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {idx, w, val};
    do @(posedge clk); while (!s_tready);
    histogram_apply(op, val, w, idx);
    if (op != OP_READ) samples_sent++;
  endtask

  int burst_left = 0;
  task automatic beat(logic [1:0] op, logic [31:0] val, logic [31:0] w,
                      logic [7:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_beat(op, val, w, idx);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (readouts_due.size() != 0 && cycles < LIMIT) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // receiver: stall pattern plus one long hold-off
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_long) m_tready <= 1'b0;
    else if (stall_phase[8]) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    readout_t e;
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (readouts_due.size() == 0) begin
        $error("readout with nothing expected");
        errors++;
      end else begin
        e = readouts_due.pop_front();
        reads_seen++;
        if (m_tdata[47:0] !== e.count) begin
          $error("bin_count exp %h got %h", e.count, m_tdata[47:0]); errors++;
        end
        if (m_tdata[111:48] !== e.variance) begin
          $error("bin_variance exp %h got %h", e.variance, m_tdata[111:48]); errors++;
        end
        if (m_tdata[143:112] !== e.err) begin
          $error("bin_error exp %h got %h", e.err, m_tdata[143:112]); errors++;
        end
      end
    end
  end

  typedef struct {
    logic [1:0]  op;
    logic [31:0] val;
    logic [31:0] w;
    logic [7:0]  idx;
    bit          typed;   // readout typed in below
    logic [47:0] count;
    logic [63:0] variance;
    logic [31:0] err;
  } row_t;

  row_t rows[$];

  function automatic row_t mk(logic [1:0] op, logic [31:0] val, logic [31:0] w,
                              logic [7:0] idx);
    row_t r;
    r = '{op, val, w, idx, 1'b0, '0, '0, '0};
    return r;
  endfunction

  function automatic row_t mkr(logic [7:0] idx, logic [47:0] c, logic [63:0] v,
                               logic [31:0] e);
    row_t r;
    r = '{OP_READ, '0, '0, idx, 1'b1, c, v, e};
    return r;
  endfunction

  task automatic random_phase(int items, int lo_bin);
    logic [1:0] op;
    logic [31:0] val, w;
    int k;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 9);
      op = (k < 5) ? OP_WEIGHTED : (k < 7) ? OP_UNWEIGHTED : (k < 9) ? OP_READ : OP_UNUSED;
      case ($urandom_range(0, 3))
        0: val = $urandom;
        default: val = h_lower + $urandom_range(0, 3 * 65536) - 65536;
      endcase
      case ($urandom_range(0, 3))
        0: w = $urandom;
        1: w = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        2: w = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: w = $urandom_range(0, 4 * 65536);
      endcase
      beat(op, val, w, $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, lo_bin)));
    end
    drain();
  endtask

  initial begin
    row_t r;
    for (int i = 0; i < 256; i++) begin
      h_count[i] = 0;
      h_var[i] = 0;
    end
    h_lower = 0; h_upper = 65536; h_scale = 16646144; h_bins = 254; h_fold = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: cleared reads, extremes of weight and value, all opcodes
    rows.push_back(mkr(8'd0, '0, '0, '0));
    rows.push_back(mkr(8'd255, '0, '0, '0));
    rows.push_back(mk(OP_WEIGHTED, 32'h8000_0000, 32'h0001_0000, 0));
    rows.push_back(mkr(8'd0, 48'h10000, 64'h1_0000_0000, 32'h10000));
    rows.push_back(mk(OP_WEIGHTED, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    rows.push_back(mk(OP_WEIGHTED, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    rows.push_back(mk(OP_WEIGHTED, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    rows.push_back(mk(OP_UNWEIGHTED, 32'h0000_0000, 0, 0));
    rows.push_back(mk(OP_WEIGHTED, 32'h0000_FFFF, 32'hFFFF_0000, 0));
    rows.push_back(mk(OP_UNUSED, 32'h0000_8000, 32'h0001_0000, 0));
    rows.push_back(mk(OP_READ, 0, 0, 8'd255));
    rows.push_back(mk(OP_READ, 0, 0, 8'd1));
    rows.push_back(mk(OP_READ, 0, 0, 8'd128));
    rows.push_back(mk(OP_READ, 0, 0, 8'd254));
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        // typed readouts stand in for the prediction
        beat(OP_READ, 0, 0, rows[i].idx);
        void'(readouts_due.pop_back());
        readouts_due.push_back('{rows[i].count, rows[i].variance, rows[i].err});
      end else begin
        beat(rows[i].op, rows[i].val, rows[i].w, rows[i].idx);
      end
    end
    drain();

    // folding, default bins
    reg_write(REG_FOLD, 32'd1);
    for (int i = 0; i < 6; i++)
      beat(OP_READ, 0, 0, i < 3 ? 8'(i) : 8'(253 + i - 3));
    random_phase(120, 255);

    // one in-range bin: folding sums all three
    reg_write(REG_BINS, 32'd1);
    reg_write(REG_LOWER, 32'hFFFF_0000);
    reg_write(REG_UPPER, 32'h0001_0000);
    reg_write(REG_SCALE, 32'h0000_8000);
    random_phase(120, 4);

    // narrow range, zero bins register, long hold-off under traffic
    reg_write(REG_BINS, 32'd0);
    reg_write(REG_FOLD, 32'd0);
    fork
      begin
        hold_long = 1'b1;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
      end
      random_phase(100, 4);
    join

    // reversed edges, large scale, 16 bins
    reg_write(REG_LOWER, 32'h0004_0000);
    reg_write(REG_UPPER, 32'hFFFC_0000);
    reg_write(REG_SCALE, 32'hFFFF_FFFF);
    reg_write(REG_BINS, 32'd16);
    random_phase(80, 20);

    // 16 bins over [-2, 2), folding on
    reg_write(REG_LOWER, 32'hFFFE_0000);
    reg_write(REG_UPPER, 32'h0002_0000);
    reg_write(REG_SCALE, 32'h0004_0000);
    reg_write(REG_FOLD, 32'd1);
    random_phase(200, 20);

    // full range, top bin count, zero scale then max bins again
    reg_write(REG_LOWER, 32'h8000_0000);
    reg_write(REG_UPPER, 32'h7FFF_FFFF);
    reg_write(REG_SCALE, 32'h0000_0000);
    reg_write(REG_BINS, 32'd255);
    random_phase(60, 255);
    reg_write(REG_SCALE, 32'h0000_00FE);
    reg_write(REG_FOLD, 32'd0);
    random_phase(160, 255);

    $display("covered %0d sample beats and %0d bin readouts over seven register settings",
             samples_sent, reads_seen);
    if (errors == 0 && readouts_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- weighted_histogram_accumulator_core.f -----
+incdir+rtl
rtl/whac_pkg.sv
rtl/whac_store.sv
rtl/whac_isqrt.sv
rtl/weighted_histogram_accumulator_core.sv
dv/tb.sv
